[hw/rtl/sps_pkg.sv]
// Shared constants and types for the Sundaram prime sieve unit.
`default_nettype none
package sps_pkg;

    localparam int MAX_N     = 65535;
    localparam int LIMIT_W   = 16;
    localparam int COUNT_W   = 16;
    localparam int MAP_DEPTH = (MAX_N - 1) / 2 + 1;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    // marking index overshoots the bound by at most a few hundred
    localparam int IDX_W     = MAP_AW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK,
        ST_COUNT,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [MAP_AW-1:0] raddr;
    } t_mem_cmd;

    typedef struct packed {
        logic               valid;
        logic               is_prime;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/sps_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sps_ram #(
    parameter int W = 1,
    parameter int D = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output      logic [W-1:0]         o_rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hw/rtl/sps_ctrl.sv]
// Sieve sequencer: clear, mark, count passes over the bitmap memory.
`default_nettype none
module sps_ctrl
    import sps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [LIMIT_W-1:0] i_limit,
    output      logic               o_idle,
    input  wire logic               i_res_taken,
    output      t_mem_cmd           o_mem_cmd,
    input  wire logic               i_rdata,
    output      t_result            o_result
);

    t_state              r_state, n_state;
    logic [MAP_AW-1:0]   r_m, n_m;
    logic [MAP_AW-1:0]   r_addr, n_addr;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_start, n_start;
    logic [IDX_W-1:0]    r_step, n_step;
    logic                r_two, n_two;
    logic                r_odd, n_odd;
    logic                r_rd_vld, n_rd_vld;
    logic                r_rd_last, n_rd_last;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_last_bit, n_last_bit;

    logic [LIMIT_W-1:0]  lim_m1;
    logic [MAP_AW-1:0]   m_in;
    logic [IDX_W-1:0]    m_ext;
    logic [IDX_W-1:0]    next_start;

    assign lim_m1     = i_limit - LIMIT_W'(1);
    assign m_in       = (i_limit == '0) ? '0 : lim_m1[MAP_AW:1];
    assign m_ext      = {2'b00, r_m};
    // start(i+1) = start(i) + 2*(2i+1) + 2
    assign next_start = r_start + {r_step[IDX_W-2:0], 1'b0} + IDX_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m        <= n_m;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_start    <= n_start;
        r_step     <= n_step;
        r_two      <= n_two;
        r_odd      <= n_odd;
        r_rd_last  <= n_rd_last;
        r_count    <= n_count;
        r_last_bit <= n_last_bit;
    end

    always_comb begin
        n_state    = r_state;
        n_m        = r_m;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_start    = r_start;
        n_step     = r_step;
        n_two      = r_two;
        n_odd      = r_odd;
        n_rd_vld   = 1'b0;
        n_rd_last  = r_rd_last;
        n_count    = r_count;
        n_last_bit = r_last_bit;
        o_mem_cmd  = '0;
        o_idle     = 1'b0;

        // tally read data in the cycle after each read
        if (r_rd_vld) begin
            if (!i_rdata) begin
                n_count = r_count + COUNT_W'(1);
            end
            if (r_rd_last) begin
                n_last_bit = i_rdata;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_m     = m_in;
                    n_addr  = '0;
                    n_two   = (i_limit == LIMIT_W'(2));
                    n_odd   = (i_limit >= LIMIT_W'(3)) && i_limit[0];
                    n_count = (i_limit >= LIMIT_W'(2)) ? COUNT_W'(1) : '0;
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_mem_cmd.we    = 1'b1;
                o_mem_cmd.waddr = r_addr;
                o_mem_cmd.wdata = 1'b0;
                if (r_addr == r_m) begin
                    // first row i = 1: start 4, step 3
                    n_idx   = IDX_W'(4);
                    n_start = IDX_W'(4);
                    n_step  = IDX_W'(3);
                    n_state = ST_MARK;
                end else begin
                    n_addr = r_addr + MAP_AW'(1);
                end
            end
            ST_MARK: begin
                if (r_idx > m_ext) begin
                    if (r_idx == r_start) begin
                        // row starts past the bound: sieve complete
                        n_addr  = MAP_AW'(1);
                        n_state = (r_m == '0) ? ST_DONE : ST_COUNT;
                    end else begin
                        n_idx   = next_start;
                        n_start = next_start;
                        n_step  = r_step + IDX_W'(2);
                    end
                end else begin
                    o_mem_cmd.we    = 1'b1;
                    o_mem_cmd.waddr = r_idx[MAP_AW-1:0];
                    o_mem_cmd.wdata = 1'b1;
                    n_idx           = r_idx + r_step;
                end
            end
            ST_COUNT: begin
                o_mem_cmd.re    = 1'b1;
                o_mem_cmd.raddr = r_addr;
                n_rd_vld        = 1'b1;
                n_rd_last       = (r_addr == r_m);
                if (r_addr == r_m) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + MAP_AW'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_result.valid    = (r_state == ST_DONE);
    assign o_result.is_prime = r_two | (r_odd & ~r_last_bit);
    assign o_result.count    = r_count;

endmodule
`default_nettype wire

[hw/rtl/sundaram_prime_sieve_unit.sv]
// Top level of the Sundaram prime sieve unit: sequencer, bitmap RAM, output register.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+------------------------------
//  input    | i_in_valid  | o_in_ready  | i_limit
//  output   | o_out_valid | i_out_ready | o_is_prime, o_prime_count
//
// One limit n at a time; m = (n-1)/2. Each transaction clears bitmap entries 0 to m,
// marks the sieve rows in turn, one write per marked entry, then counts unmarked
// entries 1 to m; its run time is set by the single write port of the bitmap RAM.
// Reset is synchronous; the bitmap needs no clearing pass after reset.
// A finished result waits in the output register while the next transaction runs.
`default_nettype none
module sundaram_prime_sieve_unit
    import sps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic [LIMIT_W-1:0] i_limit,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic               o_is_prime,
    output      logic [COUNT_W-1:0] o_prime_count
);

    t_mem_cmd           mem_cmd;
    t_result            result;
    logic               rdata;
    logic               ctrl_idle;
    logic               out_free;
    logic               load;
    logic               r_out_valid, n_out_valid;
    logic               r_is_prime;
    logic [COUNT_W-1:0] r_prime_count;

    // no transaction is taken while reset is held
    assign o_in_ready = ctrl_idle && i_rst_n;
    assign out_free   = !r_out_valid || i_out_ready;
    assign load       = result.valid && out_free;

    sps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid),
        .i_limit     (i_limit),
        .o_idle      (ctrl_idle),
        .i_res_taken (out_free),
        .o_mem_cmd   (mem_cmd),
        .i_rdata     (rdata),
        .o_result    (result)
    );

    sps_ram #(
        .W (1),
        .D (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_cmd.we),
        .i_waddr (mem_cmd.waddr),
        .i_wdata (mem_cmd.wdata),
        .i_re    (mem_cmd.re),
        .i_raddr (mem_cmd.raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_prime    <= result.is_prime;
            r_prime_count <= result.count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_is_prime    = r_is_prime;
    assign o_prime_count = r_prime_count;

    // one transaction at a time: sequencer leaves idle after accepting
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted but sequencer still idle");

    // a prime limit is always counted
    a_prime_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_prime) |-> (o_prime_count != '0))
        else $error("prime reported with zero count");

    // bitmap is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_cmd.we && mem_cmd.re))
        else $error("bitmap read and write overlap");

    // sequencer result is only taken when the output register can hold it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (result.valid && r_out_valid && !i_out_ready) |=> result.valid)
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for sundaram_prime_sieve_unit: directed and random limits, prime flag and prime count checks.
module tb;
    import sps_pkg::*;

    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int RANDOM_ITEMS = 78;
    localparam int SETTLE_CYCLES = 64;

    // limits 0 and 1, the even prime, small odd and even values, perfect squares,
    // powers of two and their neighbors, and the top of the range
    localparam logic [LIMIT_W-1:0] DIRECTED_LIMITS [22] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd9, 16'd11, 16'd15,
        16'd25, 16'd121, 16'd127, 16'd128, 16'd255, 16'd256, 16'd997, 16'd1000,
        16'd1023, 16'd65534, 16'd65535, 16'd65521
    };

    class sieve_scoreboard;
        typedef struct packed {
            logic               is_prime;
            logic [COUNT_W-1:0] count;
        } t_prime_info;

        t_prime_info expected_q[$];
        bit          odd_composite[MAP_DEPTH];
        int          errors;

        // runs the sieve over the odd indices for this limit and queues the answer
        function void note_limit(logic [LIMIT_W-1:0] lim);
            int          n;
            int          m;
            int          i;
            int          j;
            int          count;
            t_prime_info info;
            n = lim;
            if (n > MAX_N) n = MAX_N;
            m = (n >= 1) ? (n - 1) / 2 : 0;
            if (m >= MAP_DEPTH) m = MAP_DEPTH - 1;
            for (i = 0; i <= m; i++) odd_composite[i] = 1'b0;
            for (i = 1; 2 * i + 2 * i * i <= m; i++) begin
                for (j = i; i + j + 2 * i * j <= m; j++) begin
                    odd_composite[i + j + 2 * i * j] = 1'b1;
                end
            end
            count = (n >= 2) ? 1 : 0;
            for (i = 1; i <= m; i++) begin
                if (!odd_composite[i]) count++;
            end
            if (count > 65535) count = 65535;
            info.is_prime = (n == 2) || (n >= 3 && (n % 2) == 1 && !odd_composite[m]);
            info.count    = count[COUNT_W-1:0];
            expected_q.push_back(info);
        endfunction

        function void check_result(logic is_prime, logic [COUNT_W-1:0] count);
            t_prime_info want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing pending: is_prime=%0d prime_count=%0d",
                         $time, is_prime, count);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (is_prime !== want.is_prime) begin
                $display("%0t: is_prime expected %0d actual %0d", $time, want.is_prime,
                         is_prime);
                errors++;
            end
            if (count !== want.count) begin
                $display("%0t: prime_count expected %0d actual %0d", $time, want.count,
                         count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [LIMIT_W-1:0] i_limit = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_is_prime;
    logic [COUNT_W-1:0] o_prime_count;

    logic            idle_on = 1'b1;
    int              cycle_count = 0;
    sieve_scoreboard sb;

    sundaram_prime_sieve_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_limit       (i_limit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_is_prime    (o_is_prime),
        .o_prime_count (o_prime_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: check each transaction, stall at random while idling is on
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_is_prime, o_prime_count);
        end
        i_out_ready <= !idle_on || ($urandom_range(99) >= 26);
    end

    task automatic send_limit(input logic [LIMIT_W-1:0] n);
        if (idle_on && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_limit    <= n;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_limit(n);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int                 k;
        int                 sel;
        logic [LIMIT_W-1:0] lim;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_LIMITS[d]) send_limit(DIRECTED_LIMITS[d]);

        // hold off until every result is back before the random part
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            idle_on <= !(k >= 30 && k < 55);
            sel = $urandom_range(99);
            if (k == 12 || k == 50) begin
                lim = LIMIT_W'($urandom());
            end else if (sel < 10) begin
                lim = LIMIT_W'($urandom_range(4095, 1024));
            end else if (sel < 40) begin
                lim = LIMIT_W'($urandom_range(40));
            end else begin
                lim = LIMIT_W'($urandom_range(1023));
            end
            send_limit(lim);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
